@@ rtl/nsps_pkg.sv @@
// Package for the nearest snap point search core: field widths, codes,
// the world point type and the piece index wrap. No dependencies.
`default_nettype none

package nsps_pkg;

  localparam int MAX_PIECES    = 1024;
  localparam int FRACTION_BITS = 12;

  localparam int COORD_W  = 24;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int SQ_W     = 2 * COORD_W + 1;  // |diff| <= 2^24, so square <= 2^48
  localparam int DIST_W   = SQ_W + 2;         // sum of three squares
  localparam int RADIUS_W = 23;
  localparam int R2_W     = 2 * RADIUS_W;
  localparam int PIECE_W  = 10;
  localparam int TURNS_W  = 2;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

  // 0.65 in fixed point, rounded to nearest
  localparam int RADIUS_RESET_INT = ((65 << FRACTION_BITS) + 50) / 100;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(RADIUS_RESET_INT);

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPTURE_RADIUS = 1'b0
  } reg_idx_t;

  typedef enum logic {
    OP_QUERY = 1'b0,
    OP_POINT = 1'b1
  } op_t;

  typedef enum logic [TURNS_W-1:0] {
    TURN_0   = 2'd0,
    TURN_90  = 2'd1,
    TURN_180 = 2'd2,
    TURN_270 = 2'd3
  } turns_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  // Reduce a piece index into the configured piece count.
  function automatic logic [PIECE_W-1:0] piece_wrap(input logic [PIECE_W-1:0] p);
    logic [PIECE_W-1:0] r;
    if (MAX_PIECES >= (1 << PIECE_W)) begin
      r = p;
    end else begin
      r = PIECE_W'(p % MAX_PIECES);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/nsps_in_if.sv @@
// Input channel of the snap point search: valid/ready and one item.
// Depends on nsps_pkg.
`default_nettype none

interface nsps_in_if;
  import nsps_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      op;
  logic signed [COORD_W-1:0] x;
  logic signed [COORD_W-1:0] y;
  logic signed [COORD_W-1:0] z;
  logic signed [COORD_W-1:0] offset_x;
  logic signed [COORD_W-1:0] offset_y;
  logic signed [COORD_W-1:0] offset_z;
  logic [TURNS_W-1:0]        quarter_turns;
  logic [PIECE_W-1:0]        piece_index;
  logic                      last_of_piece;
  logic                      last_of_all;

  modport source (
    output valid, op, x, y, z, offset_x, offset_y, offset_z,
           quarter_turns, piece_index, last_of_piece, last_of_all,
    input  ready
  );

  modport sink (
    input  valid, op, x, y, z, offset_x, offset_y, offset_z,
           quarter_turns, piece_index, last_of_piece, last_of_all,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/nsps_out_if.sv @@
// Result channel of the snap point search: valid/ready and one result.
// Depends on nsps_pkg.
`default_nettype none

interface nsps_out_if;
  import nsps_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [PIECE_W-1:0]        out_piece;
  logic                      piece_near;
  logic                      done_res;
  logic                      found;
  logic signed [COORD_W-1:0] best_x;
  logic signed [COORD_W-1:0] best_y;
  logic signed [COORD_W-1:0] best_z;

  modport source (
    output valid, out_piece, piece_near, done_res, found, best_x, best_y, best_z,
    input  ready
  );

  modport sink (
    input  valid, out_piece, piece_near, done_res, found, best_x, best_y, best_z,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/nsps_cfg_regs.sv @@
// APB-style register port holding the capture radius.
// Depends on nsps_pkg.
`default_nettype none

module nsps_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [nsps_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [nsps_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [nsps_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready,
  output logic      [nsps_pkg::RADIUS_W-1:0]   capture_radius
);
  import nsps_pkg::*;

  logic [CFG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_radius <= RADIUS_RESET;
    end else if (wr_en && reg_idx == REG_CAPTURE_RADIUS) begin
      capture_radius <= pwdata[RADIUS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_CAPTURE_RADIUS) begin
      prdata = CFG_DATA_W'(capture_radius);
    end
  end
endmodule

`default_nettype wire

@@ rtl/nsps_world_point.sv @@
// Turns a local snap offset by a quarter-turn yaw, adds the piece origin
// and saturates each coordinate. Depends on nsps_pkg.
`default_nettype none

module nsps_world_point (
  input  wire nsps_pkg::point_t               origin,
  input  wire nsps_pkg::point_t               offset,
  input  wire logic [nsps_pkg::TURNS_W-1:0]   turns,
  output nsps_pkg::point_t                    world
);
  import nsps_pkg::*;

  logic signed [DIFF_W-1:0] lx, ly, lz;
  logic signed [DIFF_W-1:0] rx, rz;

  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [DIFF_W:0] v
  );
    logic signed [COORD_W-1:0] r;
    if (v > (DIFF_W+1)'(COORD_MAX)) begin
      r = COORD_MAX;
    end else if (v < (DIFF_W+1)'(COORD_MIN)) begin
      r = COORD_MIN;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  assign lx = DIFF_W'(offset.x);
  assign ly = DIFF_W'(offset.y);
  assign lz = DIFF_W'(offset.z);

  always_comb begin
    unique case (turns_t'(turns))
      TURN_0:   begin rx = lx;  rz = lz;  end
      TURN_90:  begin rx = lz;  rz = -lx; end
      TURN_180: begin rx = -lx; rz = -lz; end
      TURN_270: begin rx = -lz; rz = lx;  end
      default:  begin rx = lx;  rz = lz;  end
    endcase
  end

  assign world.x = sat_coord((DIFF_W+1)'(origin.x) + (DIFF_W+1)'(rx));
  assign world.y = sat_coord((DIFF_W+1)'(origin.y) + (DIFF_W+1)'(ly));
  assign world.z = sat_coord((DIFF_W+1)'(origin.z) + (DIFF_W+1)'(rz));
endmodule

`default_nettype wire

@@ rtl/nsps_dist_sq.sv @@
// Squared distance between two world points: three independent squares
// and a sum. Depends on nsps_pkg.
`default_nettype none

module nsps_dist_sq (
  input  wire nsps_pkg::point_t             a,
  input  wire nsps_pkg::point_t             b,
  output logic [nsps_pkg::DIST_W-1:0]       dist_sq
);
  import nsps_pkg::*;

  logic signed [DIFF_W-1:0]   dx, dy, dz;
  logic signed [2*DIFF_W-1:0] px, py, pz;

  assign dx = DIFF_W'(a.x) - DIFF_W'(b.x);
  assign dy = DIFF_W'(a.y) - DIFF_W'(b.y);
  assign dz = DIFF_W'(a.z) - DIFF_W'(b.z);

  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  assign dist_sq = DIST_W'(px[SQ_W-1:0]) + DIST_W'(py[SQ_W-1:0])
                 + DIST_W'(pz[SQ_W-1:0]);
endmodule

`default_nettype wire

@@ rtl/nearest_snap_point_search_core.sv @@
// Top level of the nearest snap point search: input register, world point
// and distance logic, running best, result register. Depends on nsps_pkg,
// nsps_in_if, nsps_out_if, nsps_cfg_regs, nsps_world_point, nsps_dist_sq.
//
// Channel    Dir  Beat
// ---------  ---  ------------------------------------------------------
// snap_in    in   query (op=0) or snap point (op=1) with piece flags
// snap_out   out  piece highlight, and at query end found + best point
// APB        in   capture radius at byte address 0, 32-bit data
//
// Cycles: one beat accepted per clock while the input register can advance;
// a result beat passes from the input register into the result register and
// is held there until taken. The rate is set by the compare-update loop on
// the running best distance, which sees every point in order.
// Reset: rst synchronous; search state clears to zero and the
// radius to 0.65. No clearing pass.
// Stalls: a result beat holds in the input register while the result register
// is full and not taken, blocking new beats; other beats never hold there.
`default_nettype none

module nearest_snap_point_search_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  nsps_in_if.sink                              snap_in,
  nsps_out_if.source                           snap_out,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [nsps_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [nsps_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [nsps_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready
);
  import nsps_pkg::*;

  // configuration
  logic [RADIUS_W-1:0] capture_radius;
  logic [DIST_W-1:0]   radius_sq;

  // input register
  logic               s1_valid;
  op_t                s1_op;
  point_t             s1_origin;
  point_t             s1_offset;
  logic [TURNS_W-1:0] s1_turns;
  logic [PIECE_W-1:0] s1_piece;
  logic               s1_last_piece;
  logic               s1_last_all;

  // search state
  point_t            query_point;
  logic [DIST_W-1:0] best_distance_sq;
  point_t            best_point;
  logic              any_found;
  logic              piece_hit;

  // result register
  logic               res_valid;
  logic [PIECE_W-1:0] res_piece;
  logic               res_near;
  logic               res_done;
  logic               res_found;
  point_t             res_best;

  // datapath and handshake
  point_t            world;
  logic [DIST_W-1:0] dist_sq;
  logic              in_radius;
  logic              better;
  logic              s1_has_res;
  logic              res_free;
  logic              s1_adv;
  logic              in_fire;
  logic              res_load;
  logic              piece_hit_next;
  logic              any_found_next;
  point_t            best_point_next;

  nsps_cfg_regs u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .capture_radius (capture_radius)
  );

  nsps_world_point u_world (
    .origin (s1_origin),
    .offset (s1_offset),
    .turns  (s1_turns),
    .world  (world)
  );

  nsps_dist_sq u_dist (
    .a       (world),
    .b       (query_point),
    .dist_sq (dist_sq)
  );

  // Radius squared follows the live register: the within-radius test uses
  // the current radius, a query snapshots it into the running best.
  assign radius_sq = DIST_W'(R2_W'(capture_radius) * R2_W'(capture_radius));

  assign in_radius = dist_sq < radius_sq;
  assign better    = dist_sq < best_distance_sq;   // strict: ties keep the first

  assign piece_hit_next  = piece_hit | in_radius;
  assign any_found_next  = any_found | better;
  assign best_point_next = better ? world : best_point;

  // Only a snap point flagged last of piece or last of all yields a result.
  assign s1_has_res = (s1_op == OP_POINT) && (s1_last_piece || s1_last_all);

  // Advance the input register unless its result would overrun a full,
  // untaken result register.
  assign res_free      = !res_valid || snap_out.ready;
  assign s1_adv        = s1_valid && (!s1_has_res || res_free);
  assign snap_in.ready = !s1_valid || s1_adv;
  assign in_fire       = snap_in.valid && snap_in.ready;
  assign res_load      = s1_adv && s1_has_res;

  // Capture an input beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid      <= 1'b1;
        s1_op         <= op_t'(snap_in.op);
        s1_origin     <= '{x: snap_in.x, y: snap_in.y, z: snap_in.z};
        s1_offset     <= '{x: snap_in.offset_x, y: snap_in.offset_y,
                           z: snap_in.offset_z};
        s1_turns      <= snap_in.quarter_turns;
        s1_piece      <= piece_wrap(snap_in.piece_index);
        s1_last_piece <= snap_in.last_of_piece;
        s1_last_all   <= snap_in.last_of_all;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Update the search state once per advanced beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      query_point      <= '0;
      best_distance_sq <= '0;
      best_point       <= '0;
      any_found        <= 1'b0;
      piece_hit        <= 1'b0;
    end else if (s1_adv) begin
      if (s1_op == OP_QUERY) begin
        // start a new search: load the query, reset the running best
        query_point      <= s1_origin;
        best_distance_sq <= radius_sq;
        any_found        <= 1'b0;
        piece_hit        <= 1'b0;
      end else begin
        if (better) begin
          best_distance_sq <= dist_sq;
        end
        best_point <= best_point_next;
        any_found  <= any_found_next;
        // drop the piece flag after each result
        piece_hit  <= s1_has_res ? 1'b0 : piece_hit_next;
      end
    end
  end

  // Result register: load on a result beat, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
        res_piece <= s1_piece;
        res_near  <= piece_hit_next;
        res_done  <= s1_last_all;
        res_found <= s1_last_all && any_found_next;
        res_best  <= (s1_last_all && any_found_next) ? best_point_next : '0;
      end else if (snap_out.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign snap_out.valid      = res_valid;
  assign snap_out.out_piece  = res_piece;
  assign snap_out.piece_near = res_near;
  assign snap_out.done_res   = res_done;
  assign snap_out.found      = res_found;
  assign snap_out.best_x     = res_best.x;
  assign snap_out.best_y     = res_best.y;
  assign snap_out.best_z     = res_best.z;

  // The piece flag is always clear right after a result was produced.
  a_hit_cleared: assert property (@(posedge clk) disable iff (rst)
    res_load |=> !piece_hit)
    else $error("piece_hit not cleared after a result");

  // found is only reported on a result that closes the query.
  a_found_done: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_found) |-> res_done)
    else $error("found set on a result that does not close the query");

  // A held input beat keeps its contents until it advances.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_piece) && $stable(s1_origin)))
    else $error("stalled input register changed");

  // A result waiting on a stalled sink is not lost or overwritten.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !snap_out.ready) |=> (res_valid && $stable(res_piece)
                                        && $stable(res_best)))
    else $error("pending result lost or overwritten");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking bench for nearest_snap_point_search_core: directed and random
// queries with snap points, an APB radius register and a result scoreboard.
// Depends on nsps_pkg, nsps_in_if, nsps_out_if and the core itself.
`default_nettype none

module testbench;
  import nsps_pkg::*;

  // One input beat as the bench sees it
  typedef struct {
    op_t                       op;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] off_x;
    logic signed [COORD_W-1:0] off_y;
    logic signed [COORD_W-1:0] off_z;
    turns_t                    turns;
    logic [PIECE_W-1:0]        piece;
    logic                      last_piece;
    logic                      last_all;
  } snap_item_t;

  // One result beat: piece highlight plus the closing search outcome
  typedef struct {
    logic [PIECE_W-1:0]        piece;
    logic                      near;
    logic                      done;
    logic                      found;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] bz;
  } snap_report_t;

  // Tracks the search state of the core and the reports it still owes.
  class snap_tracker;
    logic [RADIUS_W-1:0] radius;
    longint              query_pt[3];
    logic [63:0]         best_dist_sq;
    longint              best_pt[3];
    bit                  any_found;
    bit                  piece_hit;
    snap_report_t        expected_reports[$];
    int                  errors;

    function new();
      radius       = RADIUS_RESET;
      best_dist_sq = '0;
      any_found    = 0;
      piece_hit    = 0;
      errors       = 0;
      for (int i = 0; i < 3; i++) begin
        query_pt[i] = 0;
        best_pt[i]  = 0;
      end
    endfunction

    function longint clamp24(longint v);
      if (v > longint'(COORD_MAX)) return longint'(COORD_MAX);
      if (v < longint'(COORD_MIN)) return longint'(COORD_MIN);
      return v;
    endfunction

    function logic [63:0] square_of(longint d);
      logic [63:0] m;
      m = (d < 0) ? 64'(-d) : 64'(d);
      return m * m;
    endfunction

    // Advance the search by one accepted beat; queue a report if it owes one.
    function void take_item(snap_item_t it);
      longint       rot_x, rot_z;
      longint       world[3];
      logic [63:0]  dist_sq, r64, radius_sq;
      snap_report_t rep;
      r64       = 64'(radius);
      radius_sq = r64 * r64;
      if (it.op == OP_QUERY) begin
        query_pt[0]  = longint'(it.x);
        query_pt[1]  = longint'(it.y);
        query_pt[2]  = longint'(it.z);
        best_dist_sq = radius_sq;
        any_found    = 0;
        piece_hit    = 0;
        return;
      end
      case (it.turns)
        TURN_0: begin
          rot_x = longint'(it.off_x);
          rot_z = longint'(it.off_z);
        end
        TURN_90: begin
          rot_x = longint'(it.off_z);
          rot_z = -longint'(it.off_x);
        end
        TURN_180: begin
          rot_x = -longint'(it.off_x);
          rot_z = -longint'(it.off_z);
        end
        default: begin
          rot_x = -longint'(it.off_z);
          rot_z = longint'(it.off_x);
        end
      endcase
      world[0] = clamp24(longint'(it.x) + rot_x);
      world[1] = clamp24(longint'(it.y) + longint'(it.off_y));
      world[2] = clamp24(longint'(it.z) + rot_z);
      dist_sq = square_of(world[0] - query_pt[0]) + square_of(world[1] - query_pt[1])
              + square_of(world[2] - query_pt[2]);
      // within-radius uses the live radius; the running best keeps its own bound
      if (dist_sq < radius_sq) piece_hit = 1;
      if (dist_sq < best_dist_sq) begin
        best_dist_sq = dist_sq;
        for (int i = 0; i < 3; i++) best_pt[i] = world[i];
        any_found = 1;
      end
      if (!it.last_piece && !it.last_all) return;
      rep.piece = piece_wrap(it.piece);
      rep.near  = piece_hit;
      rep.done  = it.last_all;
      rep.found = it.last_all && any_found;
      rep.bx    = rep.found ? COORD_W'(best_pt[0]) : '0;
      rep.by    = rep.found ? COORD_W'(best_pt[1]) : '0;
      rep.bz    = rep.found ? COORD_W'(best_pt[2]) : '0;
      expected_reports.insert(expected_reports.size(), rep);
      piece_hit = 0;
    endfunction

    function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Compare one accepted result beat against the oldest owed report.
    function void check_result(snap_report_t act);
      snap_report_t exp_r;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual piece %h done %b",
                 $time, act.piece, act.done);
        errors++;
        return;
      end
      exp_r = expected_reports.pop_front();
      check_field("out_piece", 32'(exp_r.piece), 32'(act.piece));
      check_field("piece_near", 32'(exp_r.near), 32'(act.near));
      check_field("done_res", 32'(exp_r.done), 32'(act.done));
      check_field("found", 32'(exp_r.found), 32'(act.found));
      check_field("best_x", 32'(exp_r.bx), 32'(act.bx));
      check_field("best_y", 32'(exp_r.by), 32'(act.by));
      check_field("best_z", 32'(exp_r.bz), 32'(act.bz));
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  wire  [CFG_DATA_W-1:0] prdata;
  wire                   pready;

  nsps_in_if  snap_in_bus ();
  nsps_out_if snap_out_bus ();

  snap_tracker tracker;
  int          hold_request;  // long receiver hold-off asked by the stimulus

  nearest_snap_point_search_core u_top (
    .clk      (clk),
    .rst      (rst),
    .snap_in  (snap_in_bus),
    .snap_out (snap_out_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic snap_item_t mk(op_t op, int x, int y, int z, int ox, int oy, int oz,
                                    turns_t t, int piece, bit lp, bit la);
    snap_item_t it;
    it.op         = op;
    it.x          = COORD_W'(x);
    it.y          = COORD_W'(y);
    it.z          = COORD_W'(z);
    it.off_x      = COORD_W'(ox);
    it.off_y      = COORD_W'(oy);
    it.off_z      = COORD_W'(oz);
    it.turns      = t;
    it.piece      = PIECE_W'(piece);
    it.last_piece = lp;
    it.last_all   = la;
    return it;
  endfunction

  // Offer one beat, hold it until accepted, then note it in the tracker.
  // Entered and left at a rising edge; valid stays high on return.
  task automatic send_item(input snap_item_t it);
    snap_in_bus.valid         <= 1'b1;
    snap_in_bus.op            <= it.op;
    snap_in_bus.x             <= it.x;
    snap_in_bus.y             <= it.y;
    snap_in_bus.z             <= it.z;
    snap_in_bus.offset_x      <= it.off_x;
    snap_in_bus.offset_y      <= it.off_y;
    snap_in_bus.offset_z      <= it.off_z;
    snap_in_bus.quarter_turns <= it.turns;
    snap_in_bus.piece_index   <= it.piece;
    snap_in_bus.last_of_piece <= it.last_piece;
    snap_in_bus.last_of_all   <= it.last_all;
    // sample mid-cycle; the beat moves at the following rising edge
    do @(negedge clk); while (!snap_in_bus.ready);
    tracker.take_item(it);
    @(posedge clk);
  endtask

  task automatic pause_input(input int cycles);
    if (cycles > 0) begin
      snap_in_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Drop valid, wait for every owed report, then let in-flight beats settle
  task automatic drain_results();
    snap_in_bus.valid <= 1'b0;
    do @(posedge clk); while (tracker.expected_reports.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle, done at the edge with pready high
  task automatic write_radius(input logic [RADIUS_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(REG_CAPTURE_RADIUS) << 2;
    pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    tracker.radius = value;
  endtask

  function automatic int spread_delta(int spread);
    return int'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  // Random stimulus: mostly whole queries with pieces clustered around the
  // query point, some noise beats and some sequences with broken flags.
  task automatic run_random(input int count, input bit pause_midway);
    int                        sent;
    int                        npieces;
    int                        npts;
    int                        spread;
    bit                        burst;
    logic signed [COORD_W-1:0] cx, cy, cz;
    snap_item_t                it;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        // noise: every field fully random
        it = mk(op_t'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, turns_t'($urandom_range(0, 3)), $urandom,
                $urandom_range(0, 1), $urandom_range(0, 1));
        send_item(it);
        pause_input(rand_gap());
        sent++;
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          cx = COORD_W'($urandom);
          cy = COORD_W'($urandom);
          cz = COORD_W'($urandom);
        end else begin
          cx = COORD_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
          cy = COORD_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
          cz = COORD_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
        end
        spread = int'(tracker.radius) / 2 + 32;
        send_item(mk(OP_QUERY, cx, cy, cz, $urandom, $urandom, $urandom,
                     turns_t'($urandom_range(0, 3)), $urandom, $urandom_range(0, 1),
                     $urandom_range(0, 1)));
        if (!burst) pause_input(rand_gap());
        sent++;
        npieces = $urandom_range(1, 4);
        for (int p = 0; p < npieces; p++) begin
          npts = $urandom_range(1, 4);
          it.piece = PIECE_W'($urandom);
          it.turns = turns_t'($urandom_range(0, 3));
          for (int k = 0; k < npts; k++) begin
            it.op = OP_POINT;
            it.x  = COORD_W'(int'(cx) + spread_delta(spread));
            it.y  = COORD_W'(int'(cy) + spread_delta(spread));
            it.z  = COORD_W'(int'(cz) + spread_delta(spread));
            if ($urandom_range(0, 7) == 0) begin
              it.off_x = COORD_W'($urandom);
              it.off_y = COORD_W'($urandom);
              it.off_z = COORD_W'($urandom);
            end else begin
              it.off_x = COORD_W'(spread_delta(spread));
              it.off_y = COORD_W'(spread_delta(spread));
              it.off_z = COORD_W'(spread_delta(spread));
            end
            it.last_piece = (k == npts - 1);
            it.last_all   = (k == npts - 1) && (p == npieces - 1);
            // break the framing now and then
            if ($urandom_range(0, 19) == 0) it.last_piece = ~it.last_piece;
            if ($urandom_range(0, 19) == 0) it.last_all = ~it.last_all;
            send_item(it);
            if (!burst) pause_input(rand_gap());
            sent++;
          end
        end
      end
      if (pause_midway && sent >= count / 2) begin
        drain_results();
        pause_midway = 0;
      end
    end
  endtask

  // Receiver: random stalls, calm stretches and a long hold-off on request
  initial begin
    int           stall;
    int           calm;
    snap_report_t act;
    stall = 0;
    calm  = 0;
    snap_out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      snap_out_bus.ready <= (stall == 0);
      if (stall > 0) stall--;
      @(negedge clk);
      if (snap_out_bus.valid && snap_out_bus.ready) begin
        act.piece = snap_out_bus.out_piece;
        act.near  = snap_out_bus.piece_near;
        act.done  = snap_out_bus.done_res;
        act.found = snap_out_bus.found;
        act.bx    = snap_out_bus.best_x;
        act.by    = snap_out_bus.best_y;
        act.bz    = snap_out_bus.best_z;
        tracker.check_result(act);
      end
      if (hold_request > 0) begin
        stall        = hold_request;
        hold_request = 0;
      end else if (calm > 0) begin
        calm--;
      end else if (stall == 0) begin
        if ($urandom_range(0, 15) == 0) calm = $urandom_range(30, 80);
        else if ($urandom_range(0, 3) == 0) stall = rand_gap();
      end
    end
  end

  // Main stimulus
  initial begin
    int phase_radius[6];
    tracker      = new();
    hold_request = 0;
    rst     <= 1'b1;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    snap_in_bus.valid         <= 1'b0;
    snap_in_bus.op            <= OP_QUERY;
    snap_in_bus.x             <= '0;
    snap_in_bus.y             <= '0;
    snap_in_bus.z             <= '0;
    snap_in_bus.offset_x      <= '0;
    snap_in_bus.offset_y      <= '0;
    snap_in_bus.offset_z      <= '0;
    snap_in_bus.quarter_turns <= TURN_0;
    snap_in_bus.piece_index   <= '0;
    snap_in_bus.last_of_piece <= 1'b0;
    snap_in_bus.last_of_all   <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Points before any query: measured against the reset state
    send_item(mk(OP_POINT, 100, 0, 0, 0, 0, 0, TURN_0, 5, 1, 0));
    // last of all without last of piece
    send_item(mk(OP_POINT, 0, 50, 0, 0, 0, 0, TURN_0, 6, 0, 1));
    send_item(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, TURN_0, 0, 0, 0));
    // same offset at every yaw: equal distances, the first one must stay best
    send_item(mk(OP_POINT, 0, 0, 0, 1000, 0, 500, TURN_0, 1, 0, 0));
    send_item(mk(OP_POINT, 0, 0, 0, 1000, 0, 500, TURN_90, 1, 0, 0));
    send_item(mk(OP_POINT, 0, 0, 0, 1000, 0, 500, TURN_180, 1, 0, 0));
    send_item(mk(OP_POINT, 0, 0, 0, 1000, 0, 500, TURN_270, 1, 1, 0));
    // saturation at both ends of the coordinate range
    send_item(mk(OP_POINT, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                 COORD_MAX, TURN_0, 2, 1, 0));
    send_item(mk(OP_POINT, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                 COORD_MIN, TURN_180, 3, 0, 0));
    send_item(mk(OP_POINT, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
                 COORD_MIN, TURN_90, 3, 1, 0));
    send_item(mk(OP_POINT, 10, 10, 10, 0, 0, 0, TURN_0, 4, 1, 1));
    // points after last of all keep adding to the search
    send_item(mk(OP_POINT, 1, 1, 1, 0, 0, 0, TURN_270, 1023, 1, 0));
    send_item(mk(OP_POINT, -5, 2, 7, 0, 0, 0, TURN_0, 512, 0, 1));
    // exact hit at the top corner, distance zero
    send_item(mk(OP_QUERY, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, TURN_0, 0, 0, 0));
    send_item(mk(OP_POINT, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, TURN_0, 7, 1, 1));
    // largest possible distance
    send_item(mk(OP_QUERY, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0, TURN_0, 0, 0, 0));
    send_item(mk(OP_POINT, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, TURN_0, 8, 1, 1));
    // a point just inside and one on the radius: only the strict one counts
    send_item(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, TURN_0, 0, 0, 0));
    send_item(mk(OP_POINT, 2662, 0, 0, 0, 0, 0, TURN_0, 9, 1, 0));
    send_item(mk(OP_POINT, 0, 0, 0, 0, 0, 2661, TURN_90, 10, 1, 1));
    pause_input(rand_gap());

    run_random(120, 0);

    // Remaining phases: zero, full scale, one, 40000 and random radius,
    // then back to the reset value
    phase_radius[0] = 0;
    phase_radius[1] = 8388607;
    phase_radius[2] = 1;
    phase_radius[3] = 40000;
    phase_radius[4] = $urandom_range(0, 8388607);
    phase_radius[5] = int'(RADIUS_RESET);
    for (int p = 0; p < 6; p++) begin
      drain_results();
      write_radius(RADIUS_W'(phase_radius[p]));
      // hold the receiver off long enough to back the core up into its input
      if (p == 1) hold_request = 400;
      run_random(120, p == 3);
    end

    drain_results();
    repeat (6) @(posedge clk);
    if (tracker.expected_reports.size() != 0) begin
      $display("%0t: results missing: expected %0d more, actual 0", $time,
               tracker.expected_reports.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ nearest_snap_point_search_core.f @@
rtl/nsps_pkg.sv
rtl/nsps_in_if.sv
rtl/nsps_out_if.sv
rtl/nsps_cfg_regs.sv
rtl/nsps_world_point.sv
rtl/nsps_dist_sq.sv
rtl/nearest_snap_point_search_core.sv
tb/testbench.sv
